// ----- sv/drhf_pkg.sv -----
package drhf_pkg;

   localparam logic [7:0] RED_LIMIT = 8'd240;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_FILL_ENABLE      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOKAHEAD_LENGTH = 1'd1;

   localparam logic [4:0] LOOKAHEAD_RESET = 5'd8;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_type;

   typedef struct packed {
      logic [7:0] in_blue;
      logic [7:0] in_green;
      logic [7:0] in_red;
      logic       row_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic       out_row_end;
   } rsp_type;

   function automatic logic is_hole(pix_type p);
      return (p.blue == 8'd0) && (p.green == 8'd0) && (p.red > RED_LIMIT);
   endfunction

   function automatic logic is_valid(pix_type p);
      return (p.blue != 8'd0) && (p.green != 8'd0) && (p.red < RED_LIMIT);
   endfunction

endpackage

// ----- sv/drhf_pick.sv -----
// Replacement choice for the head pixel: priority search for the first valid
// pixel among the first lim entries, then the darker-blue of it and prev.
module drhf_pick #(
   parameter int MAX_WINDOW = 16,
   parameter int LIM_W      = 5
) (
   input  drhf_pkg::pix_type  view [MAX_WINDOW],
   input  logic [LIM_W-1:0]   lim,
   input  logic               enable,
   input  drhf_pkg::pix_type  prev,
   output drhf_pkg::pix_type  result
);
   import drhf_pkg::*;

   logic    found;
   pix_type cand;

   // scan from the far end so the lowest index wins
   always_comb begin
      found = 1'b0;
      cand  = view[0];
      for (int k = MAX_WINDOW - 1; k >= 0; k--) begin
         if (is_valid(view[k]) && (LIM_W'(k) < lim)) begin
            found = 1'b1;
            cand  = view[k];
         end
      end
   end

   always_comb begin
      result = view[0];
      if (enable && is_hole(view[0]) && found) begin
         // tie goes to the valid pixel
         result = (prev.blue < cand.blue) ? prev : cand;
      end
   end

endmodule

// ----- sv/depth_row_hole_filler_core.sv -----
// Row hole filler for color-coded depth pixels. One pixel item can be taken
// every cycle unless req_stall is high; results trail input by the lookahead
// window (pixels are held until the window behind them is full). A pixel with
// blue and green zero and red above 240 is replaced, if fill is enabled, by the
// darker-blue of the previous output and the first valid pixel in the window,
// if one exists. The last pixel of a row flushes the window: pending pixels
// leave one per cycle through the single result register unless the result
// side stalls, and req_stall stays high while the window drains or the result
// side stalls. Shrinking the window mid-row drains the excess likewise on the
// next item. Users must write registers only while idle; this is not enforced.
module depth_row_hole_filler_core #(
   parameter int MAX_WINDOW = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  drhf_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output drhf_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write,
   input  logic [drhf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [drhf_pkg::CSR_DATA_W-1:0]     csr_data
);
   import drhf_pkg::*;

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

   logic              enable_ff;
   logic [4:0]        length_ff;
   pix_type           buf_ff [MAX_WINDOW];
   pix_type           buf_in [MAX_WINDOW];
   logic [CNT_W-1:0]  fill_ff, fill_in;
   pix_type           prev_ff, prev_in;
   logic              drain_ff, drain_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              out_free, accept, go;
   logic [CMP_W-1:0]  win, lim;
   pix_type           req_pix;
   pix_type           view [MAX_WINDOW];
   pix_type           shifted [MAX_WINDOW];
   logic [CNT_W-1:0]  view_fill, rest_fill;
   logic              last_mode, emit, emit_row_end;
   pix_type           emit_pix;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = drain_ff || !out_free;
   assign accept    = req_valid && !req_stall;
   assign go        = accept || (drain_ff && out_free);

   assign req_pix.blue  = req_data.in_blue;
   assign req_pix.green = req_data.in_green;
   assign req_pix.red   = req_data.in_red;

   always_comb begin
      priority if (length_ff == 5'd0) begin
         win = CMP_W'(1);
      end else if (CMP_W'(length_ff) > CMP_W'(MAX_WINDOW)) begin
         win = CMP_W'(MAX_WINDOW);
      end else begin
         win = CMP_W'(length_ff);
      end
   end

   // buffer as seen this cycle, with the new pixel appended on accept
   always_comb begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
         view[k] = buf_ff[k];
         if (accept && (CNT_W'(k) == fill_ff)) begin
            view[k] = req_pix;
         end
      end
      view_fill = fill_ff;
      if (accept && (fill_ff < CNT_W'(MAX_WINDOW))) begin
         view_fill = fill_ff + CNT_W'(1);
      end
   end

   assign last_mode    = accept ? req_data.row_end : last_ff;
   assign emit         = go && (view_fill != '0)
                         && ((CMP_W'(view_fill) >= win) || last_mode);
   assign emit_row_end = last_mode && (view_fill == CNT_W'(1));
   assign lim          = (CMP_W'(view_fill) < win) ? CMP_W'(view_fill) : win;
   assign rest_fill    = view_fill - CNT_W'(1);

   drhf_pick #(
      .MAX_WINDOW (MAX_WINDOW),
      .LIM_W      (CMP_W)
   ) u_pick (
      .view   (view),
      .lim    (lim),
      .enable (enable_ff),
      .prev   (prev_ff),
      .result (emit_pix)
   );

   always_comb begin
      for (int k = 0; k < MAX_WINDOW - 1; k++) begin
         shifted[k] = view[k + 1];
      end
      shifted[MAX_WINDOW-1] = view[MAX_WINDOW-1];
   end

   always_comb begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
         buf_in[k] = emit ? shifted[k] : view[k];
      end
      fill_in  = emit ? rest_fill : view_fill;
      drain_in = drain_ff;
      last_in  = last_ff;
      prev_in  = prev_ff;
      if (go) begin
         drain_in = emit && (rest_fill != '0)
                    && ((CMP_W'(rest_fill) >= win) || last_mode);
         last_in  = last_mode;
      end
      if (emit) begin
         prev_in = emit_row_end ? '0 : emit_pix;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (emit) begin
         rsp_data_ff.out_blue    <= emit_pix.blue;
         rsp_data_ff.out_green   <= emit_pix.green;
         rsp_data_ff.out_red     <= emit_pix.red;
         rsp_data_ff.out_row_end <= emit_row_end;
      end
      if (reset) begin
         enable_ff    <= 1'b1;
         length_ff    <= LOOKAHEAD_RESET;
         fill_ff      <= '0;
         prev_ff      <= '0;
         drain_ff     <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         prev_ff  <= prev_in;
         drain_ff <= drain_in;
         last_ff  <= last_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            unique case (csr_index)
               CSR_FILL_ENABLE:      enable_ff <= csr_data[0];
               CSR_LOOKAHEAD_LENGTH: length_ff <= csr_data[4:0];
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_WINDOW))
      else $error("pending count beyond window storage");

   a_drain_blocks: assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> req_stall)
      else $error("item taken while window drains");

   a_row_end_empty: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_row_end) |=> (fill_ff == '0) && (prev_ff == '0) && !drain_ff)
      else $error("row end left pixels or previous output behind");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result register overwritten while stalled");

endmodule

// ----- tb/sv/depth_row_hole_filler_core_tb.sv -----
module depth_row_hole_filler_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import drhf_pkg::*;

   localparam int MAX_WIN        = 16;
   localparam int SETTLE_CYCLES  = 24;
   localparam int TAIL_CYCLES    = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_AT        = 130;
   localparam int LONG_HOLD      = 100;
   localparam int QUIET_ITEMS    = 40;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 45;
   localparam int PHASE_EN[PHASES]  = '{1, 1, 1, 0, 1, 1, 1, 1, 0, 1};
   localparam int PHASE_LEN[PHASES] = '{8, 1, 16, 16, 0, 3, 31, 12, 1, 5};

   typedef enum logic {KIND_PIXEL, KIND_CSR} stim_kind_type;

   typedef struct {
      stim_kind_type              kind;
      req_type                    pix;
      logic [CSR_INDEX_W-1:0]     reg_index;
      logic [CSR_DATA_W-1:0]      reg_value;
   } stim_entry_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   stim_entry_type stim_q[$];
   rsp_type        filled_q[$];

   int items_accepted = 0;
   int quiet_from = 0;
   int pixel_total = 0;
   int errors = 0;
   int idle_cycles = 0;
   int settle_count = 0;
   int gap_left = 0;
   int hold_left = 0;
   int burst_left = 0;
   int calm_left = 0;
   int row_left = 0;
   int run_left = 0;
   int run_kind = 0;
   bit req_taken = 1'b0;
   bit long_hold_done = 1'b0;

   // hole filler state as seen from outside
   pix_type    window_buf[MAX_WIN];
   int         held_count;
   pix_type    last_out;
   logic       fill_on;
   logic [4:0] span_len;

   // driver scratch
   logic                   next_valid;
   req_type                next_data;
   logic                   next_write;
   logic [CSR_INDEX_W-1:0] next_index;
   logic [CSR_DATA_W-1:0]  next_value;
   stim_entry_type         entry;
   rsp_type                want;

   depth_row_hole_filler_core #(.MAX_WINDOW(MAX_WIN)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit hole_px(pix_type p);
      return p.blue == 8'd0 && p.green == 8'd0 && p.red > RED_LIMIT;
   endfunction

   function automatic bit good_px(pix_type p);
      return p.blue != 8'd0 && p.green != 8'd0 && p.red < RED_LIMIT;
   endfunction

   // Pops the oldest held pixel, filling it if it is a hole and fill is on.
   task automatic emit_oldest(input int win, output rsp_type r);
      pix_type pick;
      int      lim;
      int      k;
      bit      found;
      pick = window_buf[0];
      lim = (held_count < win) ? held_count : win;
      found = 1'b0;
      if (fill_on && hole_px(pick)) begin
         for (k = 0; k < lim; k++) begin
            if (!found && good_px(window_buf[k])) begin
               found = 1'b1;
               // tie goes to the lookahead pixel
               pick = (last_out.blue < window_buf[k].blue) ? last_out : window_buf[k];
            end
         end
      end
      last_out = pick;
      for (k = 1; k < held_count; k++)
         window_buf[k-1] = window_buf[k];
      if (held_count > 0)
         held_count--;
      r.out_blue    = pick.blue;
      r.out_green   = pick.green;
      r.out_red     = pick.red;
      r.out_row_end = 1'b0;
   endtask

   task automatic run_hole_filler(input req_type px);
      rsp_type burst[MAX_WIN];
      int      n;
      int      win;
      int      k;
      win = span_len;
      if (win < 1)
         win = 1;
      if (win > MAX_WIN)
         win = MAX_WIN;
      n = 0;
      if (held_count < MAX_WIN) begin
         window_buf[held_count] = {px.in_red, px.in_green, px.in_blue};
         held_count++;
      end
      while (held_count > 0 && held_count >= win && n < MAX_WIN) begin
         emit_oldest(win, burst[n]);
         n++;
      end
      if (px.row_end) begin
         while (held_count > 0 && n < MAX_WIN) begin
            emit_oldest(win, burst[n]);
            n++;
         end
         if (n > 0)
            burst[n-1].out_row_end = 1'b1;
         last_out = '0;
      end
      for (k = 0; k < n; k++)
         filled_q.push_back(burst[k]);
   endtask

   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   task automatic queue_pixel(input logic [7:0] b, input logic [7:0] g,
                              input logic [7:0] r, input logic last);
      stim_entry_type e;
      e.kind = KIND_PIXEL;
      e.pix = '{in_blue: b, in_green: g, in_red: r, row_end: last};
      e.reg_index = '0;
      e.reg_value = '0;
      stim_q.push_back(e);
      pixel_total++;
   endtask

   task automatic queue_write(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] val);
      stim_entry_type e;
      e.kind = KIND_CSR;
      e.pix = '0;
      e.reg_index = idx;
      e.reg_value = val;
      stim_q.push_back(e);
   endtask

   // Rows built from runs of holes, valid pixels and noise.
   task automatic queue_random_pixels(input int count);
      int         i;
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
      for (i = 0; i < count; i++) begin
         if (row_left == 0)
            row_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48)
                                                   : $urandom_range(1, 20);
         if (run_left == 0) begin
            run_kind = $urandom_range(0, 9);
            run_left = $urandom_range(1, 12);
         end
         if (run_kind < 4) begin
            b = 8'd0;
            g = 8'd0;
            r = 8'($urandom_range(241, 255));
         end else if (run_kind < 8) begin
            b = 8'($urandom_range(1, 255));
            g = 8'($urandom_range(1, 255));
            r = 8'($urandom_range(0, 239));
         end else begin
            b = 8'($urandom);
            g = 8'($urandom);
            r = 8'($urandom);
            case ($urandom_range(0, 3))
               0: begin
                  b = 8'd0;
                  g = 8'd0;
                  r = RED_LIMIT;
               end
               1: r = RED_LIMIT;
               default: ;
            endcase
         end
         row_left--;
         run_left--;
         queue_pixel(b, g, r, row_left == 0);
      end
   endtask

   // stimulus, reset and end of run
   initial begin
      int  p;
      bit  finished;
      finished = 1'b0;

      // reset settings: fill on, window 8
      queue_pixel(8'd40, 8'd20, 8'd100, 1'b0);
      queue_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      queue_pixel(8'd0, 8'd0, 8'd241, 1'b0);
      queue_pixel(8'd0, 8'd0, 8'd240, 1'b0);
      queue_pixel(8'd5, 8'd5, 8'd240, 1'b0);
      queue_pixel(8'd60, 8'd5, 8'd239, 1'b0);
      queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      queue_pixel(8'd1, 8'd1, 8'd0, 1'b1);
      // hole at row start: black previous pixel wins
      queue_pixel(8'd0, 8'd0, 8'd250, 1'b0);
      queue_pixel(8'd9, 8'd9, 8'd9, 1'b1);
      // equal blue: lookahead pixel wins
      queue_pixel(8'd7, 8'd3, 8'd3, 1'b0);
      queue_pixel(8'd0, 8'd0, 8'd242, 1'b0);
      queue_pixel(8'd7, 8'd8, 8'd8, 1'b1);
      // window of one never fills
      queue_write(CSR_LOOKAHEAD_LENGTH, 5'd1);
      queue_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      queue_pixel(8'd5, 8'd5, 8'd5, 1'b0);
      queue_pixel(8'd0, 8'd0, 8'd255, 1'b1);
      // disabled passes holes through
      queue_write(CSR_FILL_ENABLE, 5'd0);
      queue_write(CSR_LOOKAHEAD_LENGTH, 5'd4);
      queue_pixel(8'd10, 8'd10, 8'd10, 1'b0);
      queue_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      queue_pixel(8'd20, 8'd20, 8'd20, 1'b1);
      // window shrinks with pixels held mid-row
      queue_write(CSR_FILL_ENABLE, 5'd1);
      queue_write(CSR_LOOKAHEAD_LENGTH, 5'd8);
      queue_pixel(8'd50, 8'd50, 8'd50, 1'b0);
      queue_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      queue_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      queue_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      queue_pixel(8'd3, 8'd3, 8'd3, 1'b0);
      queue_write(CSR_LOOKAHEAD_LENGTH, 5'd2);
      queue_pixel(8'd0, 8'd0, 8'd255, 1'b1);

      for (p = 0; p < PHASES; p++) begin
         queue_write(CSR_FILL_ENABLE, CSR_DATA_W'(PHASE_EN[p]));
         queue_write(CSR_LOOKAHEAD_LENGTH, CSR_DATA_W'(PHASE_LEN[p]));
         queue_random_pixels(PHASE_ITEMS);
      end
      stim_q[stim_q.size()-1].pix.row_end = 1'b1;
      quiet_from = pixel_total - QUIET_ITEMS;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!finished && idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (!reset && stim_q.size() == 0 && !req_valid && filled_q.size() == 0)
            finished = 1'b1;
      end
      if (finished)
         repeat (TAIL_CYCLES) @(posedge clock);
      if (finished && errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // acceptance, prediction and checking
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
         held_count = 0;
         last_out = '0;
         fill_on = 1'b1;
         span_len = LOOKAHEAD_RESET;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken || (rsp_valid && !rsp_stall) || csr_write)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (filled_q.size() == 0) begin
               $display("%0t: pixel item expected none, actual b=%0d g=%0d r=%0d end=%0d",
                        $time, rsp_data.out_blue, rsp_data.out_green,
                        rsp_data.out_red, rsp_data.out_row_end);
               errors++;
            end else begin
               want = filled_q.pop_front();
               check_field("out_blue", want.out_blue, rsp_data.out_blue);
               check_field("out_green", want.out_green, rsp_data.out_green);
               check_field("out_red", want.out_red, rsp_data.out_red);
               check_field("out_row_end", 8'(want.out_row_end),
                           8'(rsp_data.out_row_end));
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_FILL_ENABLE:      fill_on = csr_data[0];
               CSR_LOOKAHEAD_LENGTH: span_len = csr_data[4:0];
               default: ;
            endcase
         end
         if (req_taken) begin
            run_hole_filler(req_data);
            items_accepted++;
         end
      end
   end

   // pixel and register driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         csr_write <= 1'b0;
         csr_index <= '0;
         csr_data <= '0;
      end else begin
         next_valid = req_valid && !req_taken;
         next_data = req_data;
         next_write = 1'b0;
         next_index = csr_index;
         next_value = csr_data;
         if (filled_q.size() == 0 && !req_valid)
            settle_count++;
         else
            settle_count = 0;
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (stim_q.size() != 0) begin
               if (stim_q[0].kind == KIND_CSR) begin
                  // registers change only once everything has drained
                  if (settle_count >= SETTLE_CYCLES) begin
                     entry = stim_q.pop_front();
                     next_write = 1'b1;
                     next_index = entry.reg_index;
                     next_value = entry.reg_value;
                  end
               end else if (items_accepted < quiet_from && $urandom_range(0, 9) == 0) begin
                  gap_left = $urandom_range(0, 15);
               end else begin
                  entry = stim_q.pop_front();
                  next_valid = 1'b1;
                  next_data = entry.pix;
               end
            end
         end
         req_valid <= next_valid;
         req_data <= next_data;
         csr_write <= next_write;
         csr_index <= next_index;
         csr_data <= next_value;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!long_hold_done && items_accepted >= HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (items_accepted >= quiet_from) begin
            rsp_stall <= 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(0, 15);
            calm_left = $urandom_range(0, 30);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

endmodule
